>>> hw/rtl/aanf_pkg.sv
// ============================================================================
// aanf_pkg
// Shared types and constants of the Annex B access unit delimiter filter.
// ============================================================================
package aanf_pkg;

    // Low five bits of a NAL header hold the unit type.
    localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
    // Unit type of an access unit delimiter.
    localparam logic [7:0] AUD_TYPE      = 8'h09;
    // Last byte of a start code.
    localparam logic [7:0] START_BYTE    = 8'h01;
    // Number of bytes in a start code prefix.
    localparam logic [1:0] PREFIX_LEN    = 2'd3;

    // Emit command for one accepted input byte, passed from front to back.
    typedef struct packed {
        logic       pre;      // send a 00 00 01 prefix first
        logic [1:0] nz;       // number of zero bytes after the prefix
        logic       bv;       // send the data byte after the zeros
        logic [7:0] data;     // the data byte
        logic       last;     // this byte ends the buffer
    } t_cmd;

endpackage

>>> hw/rtl/aanf_front.sv
// ============================================================================
// aanf_front
// Parses the byte stream, tracks start codes and unit state, and turns each
// accepted byte into one emit command (or none).
// ============================================================================
module aanf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output logic            o_cmd_valid,
    output aanf_pkg::t_cmd  o_cmd
);

    logic [1:0] r_held_zeros, n_held_zeros;
    logic       r_inside,     n_inside;
    logic       r_hdr_pend,   n_hdr_pend;
    logic       r_drop,       n_drop;

    logic       start_code;
    logic       is_aud;
    logic       live;

    always_comb begin
        n_held_zeros = r_held_zeros;
        n_inside     = r_inside;
        n_hdr_pend   = r_hdr_pend;
        n_drop       = r_drop;
        o_cmd.pre    = 1'b0;
        o_cmd.nz     = 2'd0;
        o_cmd.bv     = 1'b0;
        o_cmd.data   = i_byte;
        o_cmd.last   = i_last;
        live         = 1'b0;

        start_code = (i_byte == aanf_pkg::START_BYTE) && (r_held_zeros == 2'd2) && !i_last;
        is_aud     = ((i_byte & aanf_pkg::NAL_TYPE_MASK) == aanf_pkg::AUD_TYPE);

        if (start_code) begin
            n_inside     = 1'b1;
            n_hdr_pend   = 1'b1;
            n_drop       = 1'b0;
            n_held_zeros = 2'd0;
        end else begin
            if (r_hdr_pend) begin
                n_hdr_pend = 1'b0;
                if (is_aud) begin
                    n_drop = 1'b1;
                end else begin
                    o_cmd.pre = 1'b1;
                end
            end
            live = r_inside && !n_drop;
            if ((i_byte == 8'd0) && !i_last) begin
                if (r_held_zeros == 2'd2) begin
                    // The oldest held zero can no longer start a start code.
                    o_cmd.nz = live ? 2'd1 : 2'd0;
                end else begin
                    n_held_zeros = r_held_zeros + 2'd1;
                end
            end else begin
                o_cmd.nz     = live ? r_held_zeros : 2'd0;
                o_cmd.bv     = live;
                n_held_zeros = 2'd0;
            end
        end

        if (i_last) begin
            n_held_zeros = 2'd0;
            n_inside     = 1'b0;
            n_hdr_pend   = 1'b0;
            n_drop       = 1'b0;
        end

        o_cmd_valid = i_accept &&
                      (o_cmd.pre || (o_cmd.nz != 2'd0) || o_cmd.bv || i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_zeros <= 2'd0;
            r_inside     <= 1'b0;
            r_hdr_pend   <= 1'b0;
            r_drop       <= 1'b0;
        end else if (i_accept) begin
            r_held_zeros <= n_held_zeros;
            r_inside     <= n_inside;
            r_hdr_pend   <= n_hdr_pend;
            r_drop       <= n_drop;
        end
    end

endmodule

>>> hw/rtl/aanf_fifo.sv
// ============================================================================
// aanf_fifo
// Small command queue between the front parser and the back emitter.
// ============================================================================
module aanf_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  aanf_pkg::t_cmd  i_wdata,
    output logic            o_full,
    input  logic            i_rd,
    output aanf_pkg::t_cmd  o_rdata,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aanf_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/aanf_back.sv
// ============================================================================
// aanf_back
// Expands emit commands into result bytes in an output register, one per
// cycle unless that register holds a result that is not popped.
// ============================================================================
module aanf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_empty,
    input  aanf_pkg::t_cmd  i_cmd,
    output logic            o_cmd_rd,
    input  logic            i_pop,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_mark,
    output logic            o_last
);

    // Command being worked off.
    logic       r_busy;
    logic [1:0] r_pre;
    logic [1:0] r_nz;
    logic       r_bv;
    logic [7:0] r_data;
    logic       r_last;

    logic       r_ov;
    logic [7:0] r_ob;
    logic       r_om;
    logic       r_ol;

    logic       have;
    logic       advance;
    logic [1:0] sel_pre, n_pre;
    logic [1:0] sel_nz,  n_nz;
    logic       sel_bv,  n_bv;
    logic [7:0] sel_data;
    logic       sel_last;
    logic [7:0] emit_byte;
    logic       emit_mark;
    logic       done;

    always_comb begin
        have     = r_busy || !i_cmd_empty;
        advance  = !r_ov || i_pop;
        sel_pre  = r_busy ? r_pre  : (i_cmd.pre ? aanf_pkg::PREFIX_LEN : 2'd0);
        sel_nz   = r_busy ? r_nz   : i_cmd.nz;
        sel_bv   = r_busy ? r_bv   : i_cmd.bv;
        sel_data = r_busy ? r_data : i_cmd.data;
        sel_last = r_busy ? r_last : i_cmd.last;

        n_pre     = sel_pre;
        n_nz      = sel_nz;
        n_bv      = sel_bv;
        emit_byte = 8'd0;
        emit_mark = 1'b0;
        if (sel_pre != 2'd0) begin
            emit_byte = (sel_pre == 2'd1) ? aanf_pkg::START_BYTE : 8'd0;
            n_pre     = sel_pre - 2'd1;
        end else if (sel_nz != 2'd0) begin
            n_nz = sel_nz - 2'd1;
        end else if (sel_bv) begin
            emit_byte = sel_data;
            n_bv      = 1'b0;
        end else begin
            emit_mark = 1'b1;
        end
        done     = (n_pre == 2'd0) && (n_nz == 2'd0) && !n_bv;
        o_cmd_rd = !r_busy && have && advance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (advance) begin
                r_ov <= have;
                if (have) begin
                    r_busy <= !done;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && have) begin
            r_pre  <= n_pre;
            r_nz   <= n_nz;
            r_bv   <= n_bv;
            r_data <= sel_data;
            r_last <= sel_last;
            r_ob   <= emit_byte;
            r_om   <= emit_mark;
            r_ol   <= sel_last && done;
        end
    end

    assign o_valid = r_ov;
    assign o_byte  = r_ob;
    assign o_mark  = r_om;
    assign o_last  = r_ol;

endmodule

>>> hw/rtl/annexb_aud_nal_filter.sv
// ============================================================================
// annexb_aud_nal_filter
// H.264 Annex B filter that re-frames NAL units and drops access unit
// delimiters.
// ============================================================================
//
//  Channel   Handshake           Payload                          Direction
//  -------   -----------------   ------------------------------   ---------
//  input     push / full         i_in_byte, i_in_last             in
//  result    empty / pop         o_out_byte, o_out_empty,         out
//                                o_out_last
//
//  One input transaction is taken per cycle while the command queue has room.
//  Each byte produces between zero and four result transactions; the back end
//  sends one result per cycle unless a result waits unpopped, so throughput
//  is bounded by the result count of each byte.
//  The first result of an accepted byte passes through the command queue and
//  then the output register before it reaches the result ports.
//  Reset is synchronous and active low; it empties the queue and the output
//  register and returns the parser to the state before the first start code.
//  A stalled result side fills the command queue, after which full rises.
//
// The front end tracks held zeros and unit state and decides, for each byte,
// how many prefix, zero and data bytes leave. Those decisions travel as
// commands through a short queue, so a burst after a unit header does not
// hold off the input side. Unless stalled by an unpopped result, the back
// end walks each command one byte per cycle into an output register that
// presents the oldest waiting result. A buffer's last byte always produces
// at least one result, an end marker with o_out_empty set if no other is due.
module annexb_aud_nal_filter #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_empty,
    output logic       o_out_last
);

    logic           accept;
    logic           cmd_valid;
    aanf_pkg::t_cmd cmd_wr;
    aanf_pkg::t_cmd cmd_rd;
    logic           cmd_empty;
    logic           cmd_pop;
    logic           out_valid;

    // The queue's full flag throttles the input directly.
    assign accept = push && !full;

    aanf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_in_byte),
        .i_last      (i_in_last),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_wr)
    );

    aanf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_valid),
        .i_wdata (cmd_wr),
        .o_full  (full),
        .i_rd    (cmd_pop),
        .o_rdata (cmd_rd),
        .o_empty (cmd_empty)
    );

    aanf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_rd),
        .o_cmd_rd    (cmd_pop),
        .i_pop       (pop),
        .o_valid     (out_valid),
        .o_byte      (o_out_byte),
        .o_mark      (o_out_empty),
        .o_last      (o_out_last)
    );

    assign empty = !out_valid;

endmodule

>>> hw/rtl/aanf_checker.sv
// ============================================================================
// aanf_checker
// Port-level checks of the Annex B filter, bound to the top level.
// ============================================================================
module aanf_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       full,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] o_out_byte,
    input  logic       o_out_empty,
    input  logic       o_out_last
);

    // A waiting result that is not taken stays on the ports unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) &&
                              $stable(o_out_empty) && $stable(o_out_last)))
        else $error("result changed while stalled");

    // An end marker only ever closes a buffer.
    a_mark_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_empty) |-> o_out_last)
        else $error("end marker without last flag");

    // An end marker carries a zero byte.
    a_mark_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_empty) |-> (o_out_byte == 8'd0))
        else $error("end marker with nonzero byte");

    // Reset leaves no result waiting.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result visible after reset");

    // Reset leaves the queue with room.
    a_rst_full: assert property (@(posedge i_clk)
        !i_rst_n |=> !full)
        else $error("full after reset");

endmodule

bind annexb_aud_nal_filter aanf_checker u_aanf_checker (.*);
